/* sv/trs_pkg.sv */
package trs_pkg;

  localparam int DATA_DEPTH_DEF = 256;

  localparam logic [7:0] TOKEN_FREE = 8'h30;
  localparam logic [7:0] TOKEN_BUSY = 8'h31;

  typedef enum logic [1:0] {
    OP_RING,
    OP_HEADER,
    OP_DATA,
    OP_INJECT
  } op_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_DEST,
    PH_SRC,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic        use_mem;
    logic [7:0]  rbyte;
    logic        done;
    logic [15:0] count;
    logic [15:0] sent;
    logic [8:0]  pos;
  } ctl_t;

endpackage

/* sv/trs_frame_mem.sv */
module trs_frame_mem
  import trs_pkg::*;
#(
  parameter int DEPTH = DATA_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/trs_ring_ctrl.sv */
module trs_ring_ctrl
  import trs_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       load_hdr,
  input  logic [7:0] byte_in,
  input  logic [7:0] dest_node,
  input  logic [7:0] src_node,
  input  logic [7:0] frame_length,
  output ctl_t       ctl
);

  phase_t      phase, phase_next;
  logic        own, own_next;
  logic [8:0]  bc, bc_next, bc_inc;
  logic [7:0]  seen, seen_next;
  logic [7:0]  pdest, psrc;
  logic [7:0]  plen, plen_next;
  logic [15:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAG;
      own   <= 1'b0;
      bc    <= '0;
      seen  <= '0;
      pdest <= '0;
      psrc  <= '0;
      plen  <= '0;
      cnt   <= '0;
    end else if (step) begin
      phase <= phase_next;
      own   <= own_next;
      bc    <= bc_next;
      seen  <= seen_next;
      plen  <= plen_next;
      cnt   <= cnt_next;
    end else if (load_hdr && !own) begin
      pdest <= dest_node;
      psrc  <= src_node;
      plen  <= frame_length;
    end
  end

  always_comb begin
    phase_next  = phase;
    own_next    = own;
    bc_next     = bc;
    seen_next   = seen;
    plen_next   = plen;
    cnt_next    = cnt;
    bc_inc      = bc + 9'd1;
    ctl.use_mem = 1'b0;
    ctl.rbyte   = byte_in;
    ctl.done    = 1'b0;
    ctl.pos     = bc;
    ctl.sent    = cnt;
    unique case (phase)
      PH_FLAG: begin
        if (byte_in == TOKEN_FREE && plen != 8'd0) begin
          own_next   = 1'b1;
          ctl.rbyte  = TOKEN_BUSY;
          phase_next = PH_DEST;
        end else if (byte_in != TOKEN_FREE) begin
          own_next   = 1'b0;
          phase_next = PH_DEST;
        end
        bc_next = '0;
      end
      PH_DEST: begin
        if (own) begin
          ctl.rbyte = pdest;
        end
        phase_next = PH_SRC;
      end
      PH_SRC: begin
        if (own) begin
          ctl.rbyte = psrc;
        end
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        bc_next = '0;
        if (own) begin
          ctl.rbyte  = plen;
          seen_next  = plen;
          phase_next = PH_DATA;
        end else begin
          seen_next  = byte_in;
          phase_next = (byte_in != 8'd0) ? PH_DATA : PH_FLAG;
        end
      end
      PH_DATA: begin
        if (own) begin
          if (bc < {1'b0, seen}) begin
            ctl.use_mem = (bc < 9'(DATA_DEPTH));
            ctl.rbyte   = 8'd0;
            bc_next     = bc_inc;
          end else begin
            ctl.rbyte  = TOKEN_FREE;
            ctl.done   = 1'b1;
            cnt_next   = cnt + 16'd1;
            plen_next  = 8'd0;
            own_next   = 1'b0;
            bc_next    = '0;
            phase_next = PH_FLAG;
          end
        end else if (bc_inc >= {1'b0, seen}) begin
          bc_next    = '0;
          phase_next = PH_FLAG;
        end else begin
          bc_next = bc_inc;
        end
      end
      default: begin
        phase_next = PH_FLAG;
        own_next   = 1'b0;
        bc_next    = '0;
      end
    endcase
    ctl.count = cnt_next;
  end

endmodule

/* sv/token_ring_station_byte_engine.sv */
// channel | handshake               | payload
// input   | in_valid / in_stall     | op, byte_in, dest_node, src_node, frame_length, data_index
// output  | out_valid / out_stall   | ring_out, frame_done, frames_sent
//
// One item per cycle while in_stall is low; a ring or inject byte goes through the buffer-read
// stage and then the output register. The frame buffer read is issued at the input transfer.
// Header and data loads produce no output.
// Synchronous reset clears station state and both stages; buffer contents stay as written.
// Input stalls only when the buffer-read stage and the output register are full and out_stall is set.
module token_ring_station_byte_engine
  import trs_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_in,
  input  logic [7:0]  dest_node,
  input  logic [7:0]  src_node,
  input  logic [7:0]  frame_length,
  input  logic [7:0]  data_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  ring_out,
  output logic        frame_done,
  output logic [15:0] frames_sent
);

  localparam int AW = $clog2(DATA_DEPTH);

  logic        accept, step, inject, wr, s1_move;
  ctl_t        ctl;
  logic [7:0]  rdata;
  logic        s1_valid, s1_use_mem, s1_done;
  logic [7:0]  s1_byte;
  logic [15:0] s1_count;

  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign step     = accept && (op == OP_RING);
  assign inject   = accept && (op == OP_INJECT);
  assign wr       = accept && (op == OP_DATA) && ({1'b0, data_index} < 9'(DATA_DEPTH));
  assign s1_move  = s1_valid && (!out_valid || !out_stall);

  trs_ring_ctrl #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .load_hdr    (accept && (op == OP_HEADER)),
    .byte_in     (byte_in),
    .dest_node   (dest_node),
    .src_node    (src_node),
    .frame_length(frame_length),
    .ctl         (ctl)
  );

  trs_frame_mem #(
    .DEPTH(DATA_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (wr),
    .waddr(data_index[AW-1:0]),
    .wdata(byte_in),
    .re   (step),
    .raddr(ctl.pos[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= step || inject;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_mem <= step && ctl.use_mem;
      s1_byte    <= step ? ctl.rbyte : TOKEN_FREE;
      s1_done    <= step && ctl.done;
      s1_count   <= step ? ctl.count : ctl.sent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ring_out    <= s1_use_mem ? rdata : s1_byte;
      frame_done  <= s1_done;
      frames_sent <= s1_count;
    end
  end

endmodule

/* sv/trs_checker.sv */
module trs_checker
  import trs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  ring_out,
  input logic        frame_done,
  input logic [15:0] frames_sent
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  a_done_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> ring_out == TOKEN_FREE && frames_sent != 16'd0)
    else $error("frame release without free token");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ring_out) && $stable(frames_sent))
    else $error("stalled output changed");

endmodule

bind token_ring_station_byte_engine trs_checker u_trs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .ring_out   (ring_out),
  .frame_done (frame_done),
  .frames_sent(frames_sent)
);
